// File: rtl/csem_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csem_pkg: shared types and constants of the counting semaphore table
// Commands, status codes, field widths and the alloc/query words that pass
// between the top level and the free-entry allocator.
// ----------------------------------------------------------------------------
package csem_pkg;

  localparam int NUM_SEMS_DEF   = 128;
  localparam int COUNT_BITS_DEF = 16;

  localparam int CMD_W       = 2;
  localparam int IDX_IN_W    = 8;
  localparam int INIT_W      = 16;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 16;

  localparam int GROUP_W     = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_OPEN  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_UP    = 2'd2,
    CMD_DOWN  = 2'd3
  } csem_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_BAD   = 3'd1,
    ST_BLOCK = 3'd2,
    ST_FULL  = 3'd3,
    ST_SAT   = 3'd4
  } csem_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } csem_state_e;

  typedef struct packed {
    logic                en;
    logic                set;
    logic [IDX_IN_W-1:0] idx;
  } csem_upd_t;

  typedef struct packed {
    logic                full;
    logic                hint_used;
    logic [IDX_IN_W-1:0] pick;
  } csem_query_t;

endpackage
`default_nettype wire

// File: rtl/csem_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csem_mem: count memory
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module csem_mem #(
  parameter int DEPTH  = 128,
  parameter int DATA_W = 16,
  parameter int ADDR_W = 7
) (
  input  wire logic              clk_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/csem_alloc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csem_alloc: in-use bits and free-entry search
// Holds one in-use flop per entry. On load, registers per-group free flags
// against the hint; the next cycle picks the first free entry at or above
// the hint, wrapping to the lowest free entry.
// ----------------------------------------------------------------------------
module csem_alloc
  import csem_pkg::*;
#(
  parameter int NUM_SEMS = NUM_SEMS_DEF,
  parameter int IDX_W    = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire logic [IDX_W-1:0] hint_i,
  input  wire csem_upd_t        upd_i,
  output csem_query_t           query_o
);

  localparam int NUM_GROUPS = (NUM_SEMS + GROUP_W - 1) / GROUP_W;
  localparam int PAD        = NUM_GROUPS * GROUP_W;
  localparam int PAD_IDX_W  = $clog2(PAD);
  localparam int GRP_IDX_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int BIT_IDX_W  = $clog2(GROUP_W);

  logic [NUM_SEMS-1:0]   in_use_q;
  logic [IDX_W-1:0]      hint_q;
  logic [NUM_GROUPS-1:0] grp_hi_q;
  logic [NUM_GROUPS-1:0] grp_any_q;

  logic [PAD-1:0]        free_pad;
  logic [PAD-1:0]        hi_in;
  logic [PAD-1:0]        hi_cur;
  logic [NUM_GROUPS-1:0] grp_hi_d;
  logic [NUM_GROUPS-1:0] grp_any_d;
  logic [IDX_W-1:0]      upd_idx;

  logic [GRP_IDX_W-1:0]  g_hi;
  logic [GRP_IDX_W-1:0]  g_any;
  logic [GRP_IDX_W-1:0]  g_sel;
  logic                  use_hi;
  logic [GROUP_W-1:0]    bits_sel;
  logic [BIT_IDX_W-1:0]  b_sel;
  logic [PAD_IDX_W-1:0]  pick_full;

  always_comb begin
    for (int i = 0; i < PAD; i++) begin
      free_pad[i] = (i < NUM_SEMS) ? !in_use_q[i] : 1'b0;
      hi_in[i]    = free_pad[i] && (i >= int'(hint_i));
      hi_cur[i]   = free_pad[i] && (i >= int'(hint_q));
    end
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_hi_d[g]  = |hi_in[g*GROUP_W +: GROUP_W];
      grp_any_d[g] = |free_pad[g*GROUP_W +: GROUP_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_hi_q  <= '0;
      grp_any_q <= '0;
      hint_q    <= '0;
    end else if (load_i) begin
      grp_hi_q  <= grp_hi_d;
      grp_any_q <= grp_any_d;
      hint_q    <= hint_i;
    end
  end

  always_comb begin
    g_hi  = '0;
    g_any = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_hi_q[g]) begin
        g_hi = GRP_IDX_W'(g);
      end
      if (grp_any_q[g]) begin
        g_any = GRP_IDX_W'(g);
      end
    end
    use_hi = |grp_hi_q;
    g_sel  = use_hi ? g_hi : g_any;
    bits_sel = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (GRP_IDX_W'(g) == g_sel) begin
        bits_sel = use_hi ? hi_cur[g*GROUP_W +: GROUP_W]
                          : free_pad[g*GROUP_W +: GROUP_W];
      end
    end
    b_sel = '0;
    for (int b = GROUP_W - 1; b >= 0; b--) begin
      if (bits_sel[b]) begin
        b_sel = BIT_IDX_W'(b);
      end
    end
    pick_full = PAD_IDX_W'(int'(g_sel) * GROUP_W + int'(b_sel));
  end

  assign upd_idx = IDX_W'(upd_i.idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else if (upd_i.en) begin
      in_use_q[upd_idx] <= upd_i.set;
    end
  end

  assign query_o.full      = !(|grp_any_q);
  assign query_o.hint_used = in_use_q[hint_q];
  assign query_o.pick      = IDX_IN_W'(pick_full);

endmodule
`default_nettype wire

// File: rtl/counting_semaphore_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_table: bank of counting semaphores
// Open, close, up and down requests on a table of counting semaphores.
// ----------------------------------------------------------------------------
// Each request word passes through an accept cycle and an execute state: in the
// accept cycle the count memory is read at the given index and the allocator
// registers its per-group free flags; in the execute state the entry is chosen,
// the count is updated and written back, and the result is loaded into the output
// register. The execute state is held for as long as an earlier result still
// sits stalled in the output register. One request is in flight at a time, so
// write-back always lands before the next read. No clearing pass follows reset:
// counts are only used for entries marked in use, and open always writes the count first.
module counting_semaphore_table
  import csem_pkg::*;
#(
  parameter int NUM_SEMS   = NUM_SEMS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [CMD_W-1:0]       command_i,
  input  wire logic [IDX_IN_W-1:0]    sem_index_i,
  input  wire logic [INIT_W-1:0]      init_value_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [STATUS_W-1:0]         status_o,
  output logic [IDX_IN_W-1:0]         sem_id_o,
  output logic                        wake_waiters_o,
  output logic [COUNT_OUT_W-1:0]      count_after_o
);

  localparam int IDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam logic [IDX_IN_W:0]     NUM_SEMS_L = (IDX_IN_W + 1)'(NUM_SEMS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

  csem_state_e state_q, state_d;

  csem_cmd_e             cmd_q;
  logic [IDX_IN_W-1:0]   idx_q;
  logic [INIT_W-1:0]     init_q;

  logic                  out_valid_q, out_valid_d;
  csem_status_e          status_q, status_d;
  logic [IDX_IN_W-1:0]   sem_id_q, sem_id_d;
  logic                  wake_q, wake_d;
  logic [COUNT_OUT_W-1:0] count_q, count_d;

  logic                  accept;
  logic                  done;
  logic                  bad_idx;
  logic                  init_sat;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_new;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  csem_upd_t             upd;
  csem_query_t           query;

  assign accept = in_valid_i && (state_q == S_IDLE);

  csem_mem #(
    .DEPTH  (NUM_SEMS),
    .DATA_W (COUNT_BITS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (IDX_W'(sem_index_i)),
    .rdata_o (cnt),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  csem_alloc #(
    .NUM_SEMS (NUM_SEMS),
    .IDX_W    (IDX_W)
  ) u_alloc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .hint_i  (IDX_W'(sem_index_i)),
    .upd_i   (upd),
    .query_o (query)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= csem_cmd_e'(command_i);
      idx_q  <= sem_index_i;
      init_q <= init_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      status_q <= status_d;
      sem_id_q <= sem_id_d;
      wake_q   <= wake_d;
      count_q  <= count_d;
    end
  end

  assign bad_idx  = {1'b0, idx_q} >= NUM_SEMS_L;
  assign init_sat = 32'(init_q) > 32'(COUNT_MAX);

  always_comb begin
    state_d   = state_q;
    done      = 1'b0;
    status_d  = ST_OK;
    sem_id_d  = idx_q;
    wake_d    = 1'b0;
    count_d   = '0;
    cnt_new   = cnt;
    mem_we    = 1'b0;
    mem_waddr = IDX_W'(idx_q);
    mem_wdata = '0;
    upd       = '{en: 1'b0, set: 1'b0, idx: idx_q};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          done    = 1'b1;
          state_d = S_IDLE;
          if (bad_idx) begin
            status_d = ST_BAD;
          end else begin
            case (cmd_q)
              CMD_OPEN: begin
                if (query.full) begin
                  status_d = ST_FULL;
                end else begin
                  cnt_new   = init_sat ? COUNT_MAX : COUNT_BITS'(init_q);
                  status_d  = init_sat ? ST_SAT : ST_OK;
                  sem_id_d  = query.pick;
                  count_d   = COUNT_OUT_W'(cnt_new);
                  mem_we    = 1'b1;
                  mem_waddr = IDX_W'(query.pick);
                  mem_wdata = cnt_new;
                  upd       = '{en: 1'b1, set: 1'b1, idx: query.pick};
                end
              end
              CMD_CLOSE: begin
                mem_we = 1'b1;
                upd    = '{en: 1'b1, set: 1'b0, idx: idx_q};
              end
              CMD_UP: begin
                if (!query.hint_used) begin
                  status_d = ST_BAD;
                end else if (cnt == COUNT_MAX) begin
                  status_d = ST_SAT;
                  count_d  = COUNT_OUT_W'(cnt);
                end else begin
                  cnt_new   = COUNT_BITS'(cnt + 1'b1);
                  wake_d    = (cnt == '0);
                  count_d   = COUNT_OUT_W'(cnt_new);
                  mem_we    = 1'b1;
                  mem_wdata = cnt_new;
                end
              end
              CMD_DOWN: begin
                if (!query.hint_used) begin
                  status_d = ST_BAD;
                end else if (cnt == '0) begin
                  status_d = ST_BLOCK;
                end else begin
                  cnt_new   = COUNT_BITS'(cnt - 1'b1);
                  count_d   = COUNT_OUT_W'(cnt_new);
                  mem_we    = 1'b1;
                  mem_wdata = cnt_new;
                end
              end
              default: begin
                status_d = ST_BAD;
              end
            endcase
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = done ? 1'b1 : (out_valid_q && out_stall_i);

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign sem_id_o       = sem_id_q;
  assign wake_waiters_o = wake_q;
  assign count_after_o  = count_q;

endmodule
`default_nettype wire

// File: rtl/csem_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csem_checker: port-level checks on the counting semaphore table
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module csem_checker
  import csem_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [STATUS_W-1:0]    status_o,
  input wire logic                   wake_waiters_o,
  input wire logic [COUNT_OUT_W-1:0] count_after_o
);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while previous word still in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(count_after_o)))
    else $error("stalled result word changed");

  a_wake_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && wake_waiters_o) |->
      (status_o == ST_OK && count_after_o == COUNT_OUT_W'(1)))
    else $error("wakeup without a successful up from zero");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_BAD || status_o == ST_FULL ||
                     status_o == ST_BLOCK)) |->
      (count_after_o == '0 && !wake_waiters_o))
    else $error("failed request reports a count or wakeup");

endmodule

bind counting_semaphore_table csem_checker u_csem_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .wake_waiters_o (wake_waiters_o),
  .count_after_o  (count_after_o)
);
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the counting semaphore table
// Drives open, close, up and down request words through the valid/stall
// handshake with random gaps and back-pressure on both sides. A scoreboard
// keeps its own copy of the semaphore bank, predicts the result word of each
// accepted request and compares every field of each returned word in order.
// ----------------------------------------------------------------------------
module tb_top;
  import csem_pkg::*;

  localparam int N_SEMS  = NUM_SEMS_DEF;
  localparam int CNT_MAX = (1 << COUNT_BITS_DEF) - 1;

  typedef struct {
    csem_status_e             status;
    logic [IDX_IN_W-1:0]      id;
    logic                     wake;
    logic [COUNT_OUT_W-1:0]   count;
  } sem_result_t;

  class sem_scoreboard;
    logic [COUNT_BITS_DEF-1:0] count_tbl [N_SEMS];
    bit                        in_use    [N_SEMS];
    sem_result_t               results_due [$];
    int                        n_requests;
    int                        n_checked;
    int                        n_errors;
    int                        n_wakes;
    int                        status_tally [8];

    function new();
      foreach (in_use[i]) begin
        in_use[i]    = 1'b0;
        count_tbl[i] = '0;
      end
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void note_request(csem_cmd_e cmd, logic [IDX_IN_W-1:0] idx,
                               logic [INIT_W-1:0] init);
      sem_result_t r;
      int          pick;
      bit          found;
      r.status = ST_OK;
      r.id     = idx;
      r.wake   = 1'b0;
      r.count  = '0;
      if (idx >= N_SEMS) begin
        r.status = ST_BAD;
      end else begin
        case (cmd)
          CMD_OPEN: begin
            found = 1'b0;
            pick  = idx;
            for (int k = 0; k < N_SEMS && !found; k++) begin
              pick  = (idx + k) % N_SEMS;
              found = !in_use[pick];
            end
            if (!found) begin
              r.status = ST_FULL;
            end else begin
              in_use[pick] = 1'b1;
              r.id         = IDX_IN_W'(pick);
              if (init > CNT_MAX) begin
                count_tbl[pick] = COUNT_BITS_DEF'(CNT_MAX);
                r.status        = ST_SAT;
              end else begin
                count_tbl[pick] = init;
              end
              r.count = count_tbl[pick];
            end
          end
          CMD_CLOSE: begin
            in_use[idx]    = 1'b0;
            count_tbl[idx] = '0;
          end
          CMD_UP: begin
            if (!in_use[idx]) begin
              r.status = ST_BAD;
            end else if (count_tbl[idx] == CNT_MAX) begin
              r.status = ST_SAT;
              r.count  = count_tbl[idx];
            end else begin
              r.wake         = (count_tbl[idx] == 0);
              count_tbl[idx] = count_tbl[idx] + 1'b1;
              r.count        = count_tbl[idx];
            end
          end
          CMD_DOWN: begin
            if (!in_use[idx]) begin
              r.status = ST_BAD;
            end else if (count_tbl[idx] == 0) begin
              r.status = ST_BLOCK;
            end else begin
              count_tbl[idx] = count_tbl[idx] - 1'b1;
              r.count        = count_tbl[idx];
            end
          end
        endcase
      end
      n_requests++;
      status_tally[int'(r.status)]++;
      if (r.wake) n_wakes++;
      results_due.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [IDX_IN_W-1:0] id,
                               logic wake, logic [COUNT_OUT_W-1:0] count);
      sem_result_t e;
      if (results_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%t: unexpected result word: status %0d id %0d wake %0b count %0d",
                   $realtime, status, id, wake, count);
        return;
      end
      e = results_due.pop_front();
      n_checked++;
      if (status !== e.status || id !== e.id || wake !== e.wake || count !== e.count) begin
        n_errors++;
        if (n_errors <= 10)
          $display({"%t: mismatch: exp status %0d id %0d wake %0b count %0d, ",
                    "got status %0d id %0d wake %0b count %0d"},
                   $realtime, e.status, e.id, e.wake, e.count, status, id, wake, count);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [CMD_W-1:0]       command_i = CMD_OPEN;
  logic [IDX_IN_W-1:0]    sem_index_i = '0;
  logic [INIT_W-1:0]      init_value_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [STATUS_W-1:0]    status_o;
  logic [IDX_IN_W-1:0]    sem_id_o;
  logic                   wake_waiters_o;
  logic [COUNT_OUT_W-1:0] count_after_o;

  sem_scoreboard sb;
  bit            idle_on = 1'b1;
  bit            hold_req = 1'b0;

  counting_semaphore_table u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .sem_index_i    (sem_index_i),
    .init_value_i   (init_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .sem_id_o       (sem_id_o),
    .wake_waiters_o (wake_waiters_o),
    .count_after_o  (count_after_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input csem_cmd_e cmd, input logic [IDX_IN_W-1:0] idx,
                           input logic [INIT_W-1:0] init);
    int gap;
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    sem_index_i  <= idx;
    init_value_i <= init;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(cmd, idx, init);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result side: check accepted words, then choose the next stall
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(status_o, sem_id_o, wake_waiters_o, count_after_o);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 250;
      end
      if (stall_left == 0 && idle_on) begin
        r = $urandom_range(0, 99);
        if (r >= 60) stall_left = (r < 92) ? $urandom_range(1, 3) : $urandom_range(6, 30);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int                  base;
    int                  r;
    int                  k;
    logic [IDX_IN_W-1:0] idx;
    logic [INIT_W-1:0]   init_v;
    csem_cmd_e           cmd;

    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(CMD_UP,    8'd5,   16'h0000);
    send_word(CMD_DOWN,  8'd5,   16'hFFFF);
    send_word(CMD_CLOSE, 8'd9,   16'h0000);
    send_word(CMD_OPEN,  8'd5,   16'h0000);
    send_word(CMD_DOWN,  8'd5,   16'h0000);
    send_word(CMD_UP,    8'd5,   16'h0000);
    send_word(CMD_UP,    8'd5,   16'h0000);
    send_word(CMD_DOWN,  8'd5,   16'h0000);
    send_word(CMD_OPEN,  8'd5,   16'hFFFF);
    send_word(CMD_UP,    8'd6,   16'h0000);
    send_word(CMD_DOWN,  8'd6,   16'h0000);
    send_word(CMD_UP,    8'd6,   16'h0000);
    send_word(CMD_UP,    8'd6,   16'h0000);
    send_word(CMD_OPEN,  8'd127, 16'hAAAA);
    send_word(CMD_OPEN,  8'd127, 16'h5555);
    send_word(CMD_UP,    8'd0,   16'h0000);
    send_word(CMD_OPEN,  8'd255, 16'h1234);
    send_word(CMD_CLOSE, 8'd128, 16'h0000);
    send_word(CMD_UP,    8'd200, 16'h0000);
    send_word(CMD_DOWN,  8'd255, 16'h0000);
    send_word(CMD_CLOSE, 8'd127, 16'h0000);
    send_word(CMD_CLOSE, 8'd0,   16'h0000);
    send_word(CMD_CLOSE, 8'd5,   16'h0000);
    send_word(CMD_CLOSE, 8'd6,   16'h0000);
    wait_drained();

    // fill the table, then knock on it while full
    for (k = 0; k < N_SEMS + 4; k++)
      send_word(CMD_OPEN, IDX_IN_W'($urandom_range(0, N_SEMS - 1)), INIT_W'($urandom));
    for (k = 0; k < 12; k++)
      send_word(k[0] ? CMD_UP : CMD_DOWN, IDX_IN_W'($urandom_range(0, N_SEMS - 1)), '0);
    for (k = 0; k < 40; k++)
      send_word(CMD_CLOSE, IDX_IN_W'($urandom_range(0, N_SEMS - 1)), INIT_W'($urandom));
    wait_drained();

    for (int b = 0; b < 6; b++) begin
      idle_on = (b != 1);
      if (b == 3) hold_req = 1'b1;
      base = $urandom_range(0, N_SEMS - 1);
      repeat (115) begin
        r = $urandom_range(0, 99);
        if (r < 80)      idx = IDX_IN_W'((base + $urandom_range(0, 11)) % N_SEMS);
        else if (r < 94) idx = IDX_IN_W'($urandom_range(0, N_SEMS - 1));
        else             idx = IDX_IN_W'($urandom_range(N_SEMS, 255));
        r = $urandom_range(0, 99);
        if (r < 15)      cmd = CMD_OPEN;
        else if (r < 27) cmd = CMD_CLOSE;
        else if (r < 65) cmd = CMD_UP;
        else             cmd = CMD_DOWN;
        r = $urandom_range(0, 9);
        if (r < 3)      init_v = '0;
        else if (r < 5) init_v = INIT_W'($urandom_range(CNT_MAX - 5, CNT_MAX));
        else            init_v = INIT_W'($urandom);
        send_word(cmd, idx, init_v);
      end
      if (b % 2 == 1) wait_drained();
    end
    idle_on = 1'b1;

    in_valid_i <= 1'b0;
    for (k = 0; k < 5000 && sb.pending() != 0; k++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    sb.n_errors += sb.pending();

    $display("Ran %0d requests, %0d results checked, %0d wakeups, %0d errors.",
             sb.n_requests, sb.n_checked, sb.n_wakes, sb.n_errors);
    $display({"Status mix: ok %0d, bad/unused %0d, would-block %0d, ",
              "full %0d, saturated %0d."},
             sb.status_tally[ST_OK], sb.status_tally[ST_BAD], sb.status_tally[ST_BLOCK],
             sb.status_tally[ST_FULL], sb.status_tally[ST_SAT]);
    if (sb.n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
